### src/keyed_flag_table_assert.svh
// Assertion macros for the keyed flag table checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef KEYED_FLAG_TABLE_ASSERT_SVH
`define KEYED_FLAG_TABLE_ASSERT_SVH

// Overlapping implication, disabled while reset is asserted.
`define KFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication checked on the following clock edge.
`define KFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/kft_pkg.sv
// Shared constants for the keyed flag table.
// No dependencies; used by the top level, the RAM user and the checker.
package kft_pkg;

    localparam int KFT_SLOTS = 128;
    localparam int KEY_W     = 16;
    localparam int FLAG_W    = 8;
    localparam int ENTRY_W   = KEY_W + FLAG_W;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

### src/kft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kft_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/keyed_flag_table.sv
// Keyed flag table: key/flag slots in one RAM, scanned in order per request.
// Depends on kft_pkg and kft_ram.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+----------------------------------------
//   request | i_valid | o_stall | i_cmd, i_vehicle_key, i_flag_bits
//   result  | o_valid | i_stall | o_found_flags, o_status
//
// A request scans the RAM one slot per cycle from slot 0, stopping at the
// first key match; a set that writes back then passes through the write state.
// The single RAM read port sets the scan rate.
// After reset, a clearing pass zeroes all SLOTS entries with o_stall high.
// A result waiting under i_stall holds; the next request is still accepted
// and scanned, and only its result waits for the register.
module keyed_flag_table #(
    parameter int SLOTS = kft_pkg::KFT_SLOTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_cmd,
    input  logic [kft_pkg::KEY_W-1:0]  i_vehicle_key,
    input  logic [kft_pkg::FLAG_W-1:0] i_flag_bits,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [kft_pkg::FLAG_W-1:0] o_found_flags,
    output logic                      o_status
);

    import kft_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_addr;
    logic              r_rd_pend;
    logic [AW-1:0]     r_rd_idx;
    logic              r_have_free;
    logic [AW-1:0]     r_wr_idx;
    logic              r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [FLAG_W-1:0] r_flags;
    logic [FLAG_W-1:0] r_hit_flags;
    logic [FLAG_W-1:0] r_res_flags;
    logic              r_res_status;
    logic              r_o_valid;
    logic [FLAG_W-1:0] r_o_found;
    logic              r_o_status;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [FLAG_W-1:0]  rd_flags;
    logic               rd_hit;
    logic               rd_free;
    logic               accept;
    logic               out_load;

    kft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .ADDR_W(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    assign rd_key   = ram_rdata[ENTRY_W-1:FLAG_W];
    assign rd_flags = ram_rdata[FLAG_W-1:0];
    assign rd_hit   = (rd_key == r_key);
    assign rd_free  = (rd_key == '0) && (rd_flags == '0);

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_load = (r_state == ST_DONE) && (!r_o_valid || !i_stall);

    assign ram_we    = (r_state == ST_CLEAR) || (r_state == ST_WRITE);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_addr : r_wr_idx;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : {r_key, r_hit_flags | r_flags};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_addr == LAST_IDX) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_rd_pend) begin
                    if (rd_hit) begin
                        n_state = (r_cmd == CMD_SET) ? ST_WRITE : ST_DONE;
                    end else if (r_rd_idx == LAST_IDX) begin
                        if ((r_cmd == CMD_SET) && (r_have_free || rd_free)) begin
                            n_state = ST_WRITE;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_WRITE: n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
                end
                ST_IDLE: begin
                    r_addr    <= '0;
                    r_rd_pend <= 1'b0;
                end
                ST_SCAN: begin
                    // Saturate at the last slot; surplus reads are ignored.
                    if (r_addr != LAST_IDX) r_addr <= r_addr + 1'b1;
                    r_rd_pend <= 1'b1;
                end
                default: begin
                    r_rd_pend <= 1'b0;
                end
            endcase
        end
    end

    // Request and scan payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= i_cmd;
            r_key        <= i_vehicle_key;
            r_flags      <= i_flag_bits;
            r_hit_flags  <= '0;
            r_have_free  <= 1'b0;
            r_res_flags  <= '0;
            r_res_status <= STATUS_DONE;
        end
        if (r_state == ST_SCAN) begin
            r_rd_idx <= r_addr;
            if (r_rd_pend) begin
                if (rd_hit) begin
                    r_wr_idx    <= r_rd_idx;
                    r_hit_flags <= rd_flags;
                    if (r_cmd == CMD_LOOKUP) r_res_flags <= rd_flags;
                end else begin
                    // Remember the lowest free slot for a set that misses.
                    if (rd_free && !r_have_free) begin
                        r_have_free <= 1'b1;
                        r_wr_idx    <= r_rd_idx;
                    end
                    if ((r_rd_idx == LAST_IDX) && (r_cmd == CMD_SET) &&
                        !(r_have_free || rd_free)) begin
                        r_res_status <= STATUS_FULL;
                    end
                end
            end
        end
        if (out_load) begin
            r_o_found  <= r_res_flags;
            r_o_status <= r_res_status;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_found_flags = r_o_found;
    assign o_status      = r_o_status;

endmodule

### src/kft_checker.sv
// Port-level checks for the keyed flag table, bound to the top level.
// Depends on kft_pkg and keyed_flag_table_assert.svh.
`include "keyed_flag_table_assert.svh"

module kft_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [kft_pkg::FLAG_W-1:0] o_found_flags,
    input logic                      o_status
);

    import kft_pkg::*;

    // A held result keeps its payload while the consumer stalls.
    `KFT_ASSERT_NEXT(a_hold_result, o_valid && i_stall, o_valid && $stable(o_found_flags) && $stable(o_status), "result changed under stall")

    // A full table report never carries flags.
    `KFT_ASSERT_NOW(a_full_no_flags, o_valid && (o_status == STATUS_FULL), o_found_flags == '0, "full status with nonzero flags")

    // One request at a time: a transfer in makes the block busy next cycle.
    `KFT_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall, "request side not busy after transfer")

    // No result leaves right after reset.
    `KFT_ASSERT_NOW(a_quiet_after_reset, $past(!i_rst_n), !o_valid, "result valid right after reset")

endmodule

bind keyed_flag_table kft_checker u_kft_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_found_flags(o_found_flags),
    .o_status     (o_status)
);
